// ===== src/rts_pkg.sv =====
// Shared types, codes and helpers for the reduction tree scoreboard.
// No dependencies; rts_table, rts_seq and the top level import this package.
`default_nettype none
package rts_pkg;

  localparam int MAX_NODES = 64;
  localparam int NODE_W    = 6;   // node address bits
  localparam int IDX_W     = 7;   // node index with the "none" code
  localparam int OWNER_W   = 64;
  localparam int ERR_W     = 16;

  localparam logic [IDX_W-1:0] NONE_IDX = 7'd64;

  // request modes
  localparam logic [2:0] MD_LOAD   = 3'd0;
  localparam logic [2:0] MD_CLAIM  = 3'd1;
  localparam logic [2:0] MD_COMMIT = 3'd2;
  localparam logic [2:0] MD_QUERY  = 3'd3;
  localparam logic [2:0] MD_STATUS = 3'd4;
  localparam logic [2:0] MD_CANCEL = 3'd5;
  localparam logic [2:0] MD_RETIRE = 3'd6;

  // answer status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_STALE   = 3'd1;
  localparam logic [2:0] ST_INVALID = 3'd2;
  localparam logic [2:0] ST_NOTHERE = 3'd3;
  localparam logic [2:0] ST_FAILED  = 3'd4;
  localparam logic [2:0] ST_BUSY    = 3'd5;

  // node progress codes
  localparam logic [1:0] PR_WAITING  = 2'd0;
  localparam logic [1:0] PR_BORROWED = 2'd1;
  localparam logic [1:0] PR_READY    = 2'd2;
  localparam logic [1:0] PR_FAILED   = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_PROGRAM    = 3'd0;
  localparam logic [2:0] CFG_INVOCATION = 3'd1;
  localparam logic [2:0] CFG_OWNER      = 3'd2;
  localparam logic [2:0] CFG_COUNT      = 3'd3;
  localparam logic [2:0] CFG_CANCEL     = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TOK1,
    S_TOK2,
    S_EV0,
    S_EV1,
    S_EV2,
    S_LOAD,
    S_LOAD2,
    S_RT0,
    S_RT1,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_TGT,
    PH_LEFT,
    PH_RIGHT
  } phase_t;

  typedef struct packed {
    logic [2:0]       st;
    logic             flag;
    logic [ERR_W-1:0] err;
  } ans_t;

  typedef struct packed {
    logic [OWNER_W-1:0] program_id;
    logic [OWNER_W-1:0] invocation_id;
    logic [OWNER_W-1:0] local_owner;
    logic [IDX_W-1:0]   cnt;          // effective node count, at most MAX_NODES
    logic [ERR_W-1:0]   cancel_code;
  } cfg_t;

  // sequencer to node tables
  typedef struct packed {
    logic [NODE_W-1:0]  raddr;
    logic [NODE_W-1:0]  own_raddr;
    logic               lay_we;
    logic               own_we;
    logic               prog_we;
    logic               err_we;
    logic [NODE_W-1:0]  waddr;
    logic [2*IDX_W-1:0] lay_wdata;    // {left, right}
    logic [OWNER_W-1:0] own_wdata;
    logic [1:0]         prog_wdata;
    logic [ERR_W-1:0]   err_wdata;
    logic               par_we;
    logic [NODE_W-1:0]  par_waddr;
    logic [NODE_W-1:0]  par_wdata;
    logic               clr;          // retire: all progress back to waiting
  } tbl_req_t;

  // node tables to sequencer, in the cycle after the read address
  typedef struct packed {
    logic [IDX_W-1:0]   left;
    logic [IDX_W-1:0]   right;
    logic [OWNER_W-1:0] own;
    logic [IDX_W-1:0]   par;
    logic [1:0]         prog;
    logic [ERR_W-1:0]   err;
  } tbl_rd_t;

  // flag only with ok, error only with failed
  function automatic ans_t mk(logic [2:0] st, logic flag, logic [ERR_W-1:0] err);
    ans_t a;
    a.st   = st;
    a.flag = (st == ST_OK) ? flag : 1'b0;
    a.err  = (st == ST_FAILED) ? err : '0;
    return a;
  endfunction

  // ready query answer of one node
  function automatic ans_t rq(logic needed, logic [ERR_W-1:0] gerr, logic [1:0] prog,
                              logic [ERR_W-1:0] err);
    ans_t a;
    if (!needed) begin
      a = mk(ST_INVALID, 1'b0, '0);
    end else if (gerr != '0) begin
      a = mk(ST_FAILED, 1'b0, gerr);
    end else if (prog == PR_FAILED) begin
      a = mk(ST_FAILED, 1'b0, err);
    end else begin
      a = mk(ST_OK, prog == PR_READY, '0);
    end
    return a;
  endfunction

endpackage
`default_nettype wire

// ===== src/rts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module rts_ram #(
  parameter int W  = 8,
  parameter int AW = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/rts_table.sv =====
// Per-node stores: layout, owner, parent, progress and error RAMs with valid bits.
// Depends on rts_pkg and rts_ram.
`default_nettype none
module rts_table (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire rts_pkg::tbl_req_t                 req,
  output rts_pkg::tbl_rd_t                       rd,
  output logic [rts_pkg::MAX_NODES-1:0]          claimed
);
  import rts_pkg::*;

  logic [MAX_NODES-1:0] prog_vld;
  logic                 par_vld_q;
  logic                 prog_vld_q;
  logic [2*IDX_W-1:0]   lay_q;
  logic [NODE_W-1:0]    par_q;
  logic [1:0]           prog_q;

  rts_ram #(.W(2*IDX_W), .AW(NODE_W)) u_lay (
    .clk(clk), .we(req.lay_we), .waddr(req.waddr), .wdata(req.lay_wdata),
    .raddr(req.raddr), .rdata(lay_q)
  );

  rts_ram #(.W(OWNER_W), .AW(NODE_W)) u_own (
    .clk(clk), .we(req.own_we), .waddr(req.waddr), .wdata(req.own_wdata),
    .raddr(req.own_raddr), .rdata(rd.own)
  );

  rts_ram #(.W(NODE_W), .AW(NODE_W)) u_par (
    .clk(clk), .we(req.par_we), .waddr(req.par_waddr), .wdata(req.par_wdata),
    .raddr(req.raddr), .rdata(par_q)
  );

  rts_ram #(.W(2), .AW(NODE_W)) u_prog (
    .clk(clk), .we(req.prog_we), .waddr(req.waddr), .wdata(req.prog_wdata),
    .raddr(req.raddr), .rdata(prog_q)
  );

  rts_ram #(.W(ERR_W), .AW(NODE_W)) u_err (
    .clk(clk), .we(req.err_we), .waddr(req.waddr), .wdata(req.err_wdata),
    .raddr(req.raddr), .rdata(rd.err)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      claimed  <= '0;
      prog_vld <= '0;
    end else begin
      if (req.par_we) begin
        claimed[req.par_waddr] <= 1'b1;
      end
      if (req.clr) begin
        prog_vld <= '0;
      end else if (req.prog_we) begin
        prog_vld[req.waddr] <= 1'b1;
      end
    end
  end

  // valid bits are registered together with the RAM read data
  always_ff @(posedge clk) begin
    par_vld_q  <= claimed[req.raddr];
    prog_vld_q <= prog_vld[req.raddr];
  end

  assign rd.left  = lay_q[2*IDX_W-1:IDX_W];
  assign rd.right = lay_q[IDX_W-1:0];
  assign rd.par   = par_vld_q ? {1'b0, par_q} : NONE_IDX;
  assign rd.prog  = prog_vld_q ? prog_q : PR_WAITING;

  // a child gets its parent once only
  a_par_once: assert property (@(posedge clk) disable iff (rst)
    req.par_we |-> !claimed[req.par_waddr])
    else $error("parent entry written twice");

endmodule
`default_nettype wire

// ===== src/rts_seq.sv =====
// Request sequencer: token check, node evaluation, tree walks and the answer register.
// Depends on rts_pkg; drives the node tables in rts_table.
`default_nettype none
module rts_seq (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire rts_pkg::cfg_t                 cfg,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [2:0]                    mode,
  input  wire logic [rts_pkg::NODE_W-1:0]    node,
  input  wire logic [rts_pkg::IDX_W-1:0]     left_child,
  input  wire logic [rts_pkg::IDX_W-1:0]     right_child,
  input  wire logic [rts_pkg::OWNER_W-1:0]   node_owner,
  input  wire logic [rts_pkg::OWNER_W-1:0]   token_program,
  input  wire logic [rts_pkg::OWNER_W-1:0]   token_invocation,
  input  wire logic [rts_pkg::ERR_W-1:0]     error_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [2:0]                         status,
  output logic                               flag,
  output logic [rts_pkg::ERR_W-1:0]          error_code,
  output rts_pkg::tbl_req_t                  tq,
  input  wire rts_pkg::tbl_rd_t              rd,
  input  wire logic [rts_pkg::MAX_NODES-1:0] claimed
);
  import rts_pkg::*;

  state_t state, state_next;

  // request word
  logic [2:0]         mode_q;
  logic [NODE_W-1:0]  node_q;
  logic [IDX_W-1:0]   l_q, r_q;
  logic [OWNER_W-1:0] owner_q, tp_q, ti_q;
  logic [ERR_W-1:0]   ev_q;

  // walk and evaluation registers
  logic [IDX_W-1:0]   x;
  phase_t             phase;
  logic               complete;
  logic               own_hit;
  logic [IDX_W-1:0]   ex_par, ex_left, ex_right, tgt_right;
  logic [1:0]         ex_prog, tgt_prog;
  logic [ERR_W-1:0]   ex_err, tgt_err;
  logic [ERR_W-1:0]   gerr;
  ans_t               ans;

  logic               accept;
  logic [IDX_W-1:0]   x_inc;
  logic [OWNER_W-1:0] cmp_a, cmp_b;
  logic               cmp_eq;

  // evaluation decision
  logic               needed;
  ans_t               rq_ans;
  logic               ev_finish, ev_more, ev_cplt, ev_prog_we, ev_err_we;
  ans_t               ev_ans;
  logic [IDX_W-1:0]   ev_nx;
  phase_t             ev_nphase;
  logic [1:0]         ev_prog_wd, fin_prog;
  logic [ERR_W-1:0]   fin_err;

  logic               ld_leaf, ld_inv;
  logic               rt_busy, rt_last, ret_clr;

  assign accept = in_valid && in_ready;
  assign x_inc  = x + 7'd1;

  // the one shared 64-bit comparator
  always_comb begin
    case (state)
      S_TOK1: begin
        cmp_a = tp_q;
        cmp_b = cfg.program_id;
      end
      S_TOK2: begin
        cmp_a = ti_q;
        cmp_b = cfg.invocation_id;
      end
      default: begin
        cmp_a = rd.own;
        cmp_b = cfg.local_owner;
      end
    endcase
  end
  assign cmp_eq = (cmp_a == cmp_b);

  assign needed = (x < cfg.cnt) && (own_hit || (ex_par == NONE_IDX) || cmp_eq);
  assign rq_ans = rq(needed, gerr, ex_prog, ex_err);
  assign fin_prog = (phase == PH_TGT) ? ex_prog : tgt_prog;
  assign fin_err  = (phase == PH_TGT) ? ex_err : tgt_err;

  always_comb begin
    ev_finish  = 1'b0;
    ev_more    = 1'b0;
    ev_ans     = mk(ST_OK, 1'b0, '0);
    ev_nx      = x;
    ev_nphase  = phase;
    ev_cplt    = complete;
    ev_prog_we = 1'b0;
    ev_prog_wd = PR_WAITING;
    ev_err_we  = 1'b0;
    case (mode_q)
      MD_QUERY: begin
        ev_finish = 1'b1;
        ev_ans    = rq_ans;
      end
      MD_CLAIM: begin
        ev_finish = 1'b1;
        if (phase == PH_TGT && !needed) begin
          ev_ans = mk(ST_NOTHERE, 1'b0, '0);
        end else if (phase == PH_TGT && gerr != '0) begin
          ev_ans = mk(ST_FAILED, 1'b0, gerr);
        end else if (phase == PH_TGT && own_hit && ex_left != NONE_IDX) begin
          ev_finish = 1'b0;
          ev_more   = 1'b1;
          ev_nx     = ex_left;
          ev_nphase = PH_LEFT;
        end else if (phase != PH_TGT && (rq_ans.st != ST_OK || !rq_ans.flag)) begin
          ev_ans = rq_ans;
        end else if (phase == PH_LEFT) begin
          ev_finish = 1'b0;
          ev_more   = 1'b1;
          ev_nx     = tgt_right;
          ev_nphase = PH_RIGHT;
        end else if (fin_prog == PR_WAITING) begin
          ev_prog_we = 1'b1;
          ev_prog_wd = PR_BORROWED;
          ev_ans     = mk(ST_OK, 1'b1, '0);
        end else if (fin_prog == PR_FAILED) begin
          ev_ans = mk(ST_FAILED, 1'b0, fin_err);
        end else begin
          ev_ans = mk(ST_OK, 1'b0, '0);
        end
      end
      MD_COMMIT: begin
        ev_finish = 1'b1;
        if (!needed) begin
          ev_ans = mk(ST_NOTHERE, 1'b0, '0);
        end else if (ex_prog != PR_BORROWED) begin
          ev_ans = mk(ST_INVALID, 1'b0, '0);
        end else begin
          ev_prog_we = 1'b1;
          ev_prog_wd = (ev_q != '0) ? PR_FAILED : PR_READY;
          ev_err_we  = (ev_q != '0);
          ev_ans     = mk(ST_OK, 1'b0, '0);
        end
      end
      MD_STATUS: begin
        ev_cplt = complete & (!needed | rq_ans.flag);
        if (needed && rq_ans.st != ST_OK) begin
          ev_finish = 1'b1;
          ev_ans    = rq_ans;
        end else if (x_inc >= cfg.cnt) begin
          ev_finish = 1'b1;
          ev_ans    = mk(ST_OK, ev_cplt, '0);
        end else begin
          ev_more = 1'b1;
          ev_nx   = x_inc;
        end
      end
      default: begin
        ev_finish = 1'b1;
        ev_ans    = mk(ST_INVALID, 1'b0, '0);
      end
    endcase
  end

  // load checks: node below the count, children below the node, distinct and still without a parent
  assign ld_leaf = (l_q == NONE_IDX) && (r_q == NONE_IDX);
  assign ld_inv  = ({1'b0, node_q} >= cfg.cnt) ||
                   (!ld_leaf && ((l_q >= {1'b0, node_q}) || (r_q >= {1'b0, node_q}) ||
                                 (l_q == r_q) || claimed[l_q[NODE_W-1:0]] ||
                                 claimed[r_q[NODE_W-1:0]]));

  assign rt_busy = (rd.prog == PR_BORROWED);
  assign rt_last = (x_inc >= cfg.cnt);
  assign ret_clr = (state == S_RT1 && !rt_busy && rt_last) ||
                   (accept && mode == MD_RETIRE && cfg.cnt == '0);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (mode)
            MD_LOAD:             state_next = S_LOAD;
            MD_CLAIM, MD_COMMIT: state_next = S_TOK1;
            MD_QUERY:            state_next = S_EV0;
            MD_STATUS:           state_next = (cfg.cnt == '0) ? S_DONE : S_EV0;
            MD_RETIRE:           state_next = (cfg.cnt == '0) ? S_DONE : S_RT0;
            default:             state_next = S_DONE;
          endcase
        end
      end
      S_TOK1:  state_next = cmp_eq ? S_TOK2 : S_DONE;
      S_TOK2:  state_next = (cmp_eq && {1'b0, node_q} < cfg.cnt) ? S_EV0 : S_DONE;
      S_EV0:   state_next = S_EV1;
      S_EV1:   state_next = S_EV2;
      S_EV2:   state_next = ev_more ? S_EV0 : S_DONE;
      S_LOAD:  state_next = (!ld_inv && !ld_leaf) ? S_LOAD2 : S_DONE;
      S_LOAD2: state_next = S_DONE;
      S_RT0:   state_next = S_RT1;
      S_RT1:   state_next = (rt_busy || rt_last) ? S_DONE : S_RT0;
      S_DONE:  state_next = (!out_valid || out_ready) ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  // table requests and handshake outputs
  always_comb begin
    tq            = '0;
    tq.raddr      = x[NODE_W-1:0];
    tq.own_raddr  = (state == S_EV1) ? rd.par[NODE_W-1:0] : x[NODE_W-1:0];
    tq.waddr      = node_q;
    tq.lay_wdata  = {l_q, r_q};
    tq.own_wdata  = owner_q;
    tq.prog_wdata = ev_prog_wd;
    tq.err_wdata  = ev_q;
    tq.par_wdata  = node_q;
    tq.par_waddr  = l_q[NODE_W-1:0];
    tq.clr        = ret_clr;
    case (state)
      S_LOAD: begin
        tq.lay_we = !ld_inv;
        tq.own_we = !ld_inv;
        tq.par_we = !ld_inv && !ld_leaf;
      end
      S_LOAD2: begin
        tq.par_we    = 1'b1;
        tq.par_waddr = r_q[NODE_W-1:0];
      end
      S_EV2: begin
        tq.prog_we = ev_prog_we;
        tq.err_we  = ev_err_we;
      end
      default: begin
      end
    endcase
    in_ready = (state == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      gerr      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && mode == MD_CANCEL && gerr == '0) begin
        gerr <= (error_value != '0) ? error_value : cfg.cancel_code;
      end else if (ret_clr) begin
        gerr <= '0;
      end
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          mode_q   <= mode;
          node_q   <= node;
          l_q      <= left_child;
          r_q      <= right_child;
          owner_q  <= node_owner;
          tp_q     <= token_program;
          ti_q     <= token_invocation;
          ev_q     <= error_value;
          x        <= (mode == MD_QUERY) ? {1'b0, node} : '0;
          phase    <= PH_TGT;
          complete <= 1'b1;
          case (mode)
            // an empty status walk reports a complete tree
            MD_STATUS:            ans <= mk(ST_OK, 1'b1, '0);
            MD_CANCEL, MD_RETIRE: ans <= mk(ST_OK, 1'b0, '0);
            default:              ans <= mk(ST_INVALID, 1'b0, '0);
          endcase
        end
      end
      S_TOK1: begin
        ans <= mk(ST_STALE, 1'b0, '0);
      end
      S_TOK2: begin
        x <= {1'b0, node_q};
        if (!cmp_eq) begin
          ans <= mk(ST_STALE, 1'b0, '0);
        end else begin
          ans <= mk(ST_INVALID, 1'b0, '0);
        end
      end
      S_EV1: begin
        own_hit  <= cmp_eq;
        ex_par   <= rd.par;
        ex_prog  <= rd.prog;
        ex_err   <= rd.err;
        ex_left  <= rd.left;
        ex_right <= rd.right;
      end
      S_EV2: begin
        if (phase == PH_TGT) begin
          tgt_right <= ex_right;
          tgt_prog  <= ex_prog;
          tgt_err   <= ex_err;
        end
        complete <= ev_cplt;
        if (ev_finish) begin
          ans <= ev_ans;
        end
        if (ev_more) begin
          x     <= ev_nx;
          phase <= ev_nphase;
        end
      end
      S_LOAD: begin
        ans <= ld_inv ? mk(ST_INVALID, 1'b0, '0) : mk(ST_OK, 1'b0, '0);
      end
      S_RT1: begin
        if (rt_busy) begin
          ans <= mk(ST_BUSY, 1'b0, '0);
        end else if (rt_last) begin
          ans <= mk(ST_OK, 1'b0, '0);
        end else begin
          x <= x_inc;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          status     <= ans.st;
          flag       <= ans.flag;
          error_code <= ans.err;
        end
      end
      default: begin
      end
    endcase
  end

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("accepted word did not start work");

  a_gerr_sticky: assert property (@(posedge clk) disable iff (rst)
    (gerr != '0) |=> (gerr == $past(gerr)) || (gerr == '0))
    else $error("global error overwritten");

  a_prog_write: assert property (@(posedge clk) disable iff (rst)
    tq.prog_we |-> (state == S_EV2) && (mode_q == MD_CLAIM || mode_q == MD_COMMIT))
    else $error("progress written outside claim or commit");

endmodule
`default_nettype wire

// ===== src/reduction_tree_scoreboard.sv =====
// Top level of the reduction tree scoreboard: configuration registers and wiring.
// Depends on rts_pkg, rts_seq and rts_table (which uses rts_ram).
//
// Use: load the tree one node per word (mode load), then drive claim, commit,
// ready query, status, cancel and retire words. Every accepted word gives
// exactly one result word.
// Channels: in_valid/in_ready carry a request word, out_valid/out_ready a
// result word, cfg_valid/cfg_ready a register write (cfg_ready is always high;
// write only while the block is idle). Indexes past cancel_code are ignored.
// Work per word: cancel and an unknown mode go straight to the result; a load
// that is neither a leaf nor refused writes the parent of its second child in a
// further step; claim and commit end early on a stale program id, a stale
// invocation id or a node past the count, and a locally owned claim also checks
// each child; status and retire walk the nodes in turn. The one shared 64-bit
// comparator and the single read port of each node RAM set these steps.
// in_ready rises at the edge that registers the result.
// The output register holds a finished word, so a new word is accepted while
// the receiver stalls; the next result then waits until the slot frees.
// Reset clears parents, progress, the global error and the control and
// configuration registers at once; no clearing pass is needed.
`default_nettype none
module reduction_tree_scoreboard (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // configuration
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [2:0]                   cfg_index,
  input  wire logic [63:0]                  cfg_data,
  // request words
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [2:0]                   mode,
  input  wire logic [rts_pkg::NODE_W-1:0]   node,
  input  wire logic [rts_pkg::IDX_W-1:0]    left_child,
  input  wire logic [rts_pkg::IDX_W-1:0]    right_child,
  input  wire logic [rts_pkg::OWNER_W-1:0]  node_owner,
  input  wire logic [rts_pkg::OWNER_W-1:0]  token_program,
  input  wire logic [rts_pkg::OWNER_W-1:0]  token_invocation,
  input  wire logic [rts_pkg::ERR_W-1:0]    error_value,
  // result words
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [2:0]                        status,
  output logic                              flag,
  output logic [rts_pkg::ERR_W-1:0]         error_code
);
  import rts_pkg::*;

  logic [OWNER_W-1:0]   program_id, invocation_id, local_owner;
  logic [IDX_W-1:0]     node_count;
  logic [ERR_W-1:0]     cancel_code;
  cfg_t                 cfg;
  tbl_req_t             tq;
  tbl_rd_t              rd;
  logic [MAX_NODES-1:0] claimed;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      program_id    <= '0;
      invocation_id <= '0;
      local_owner   <= '0;
      node_count    <= 7'd1;
      cancel_code   <= 16'd125;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PROGRAM:    program_id    <= cfg_data;
        CFG_INVOCATION: invocation_id <= cfg_data;
        CFG_OWNER:      local_owner   <= cfg_data;
        CFG_COUNT:      node_count    <= cfg_data[IDX_W-1:0];
        CFG_CANCEL:     cancel_code   <= cfg_data[ERR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // counts above the table size are clipped to it
  always_comb begin
    cfg.program_id    = program_id;
    cfg.invocation_id = invocation_id;
    cfg.local_owner   = local_owner;
    cfg.cancel_code   = cancel_code;
    cfg.cnt           = (node_count > IDX_W'(MAX_NODES)) ? IDX_W'(MAX_NODES) : node_count;
  end

  rts_seq u_seq (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .node(node),
    .left_child(left_child),
    .right_child(right_child),
    .node_owner(node_owner),
    .token_program(token_program),
    .token_invocation(token_invocation),
    .error_value(error_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .flag(flag),
    .error_code(error_code),
    .tq(tq),
    .rd(rd),
    .claimed(claimed)
  );

  rts_table u_table (
    .clk(clk),
    .rst(rst),
    .req(tq),
    .rd(rd),
    .claimed(claimed)
  );

endmodule
`default_nettype wire
